// ----- design/tcw_pkg.sv -----
// shared constants, types and address helpers for the text console writer
package tcw_pkg;

  // screen geometry and scrollback depth
  localparam int COLS          = 80;
  localparam int ROWS          = 25;
  localparam int HISTORY_LINES = 100;

  localparam int COL_W  = $clog2(COLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ROWP_W = ROW_W + 1;
  localparam int HIST_W = (HISTORY_LINES > 1) ? $clog2(HISTORY_LINES) : 1;
  localparam int FILL_W = $clog2(HISTORY_LINES + 1);
  localparam int CNT_W  = $clog2(COLS + 1);
  localparam int SCR_AW = $clog2(ROWS * COLS);
  localparam int HIS_AW = $clog2(HISTORY_LINES * COLS);
  localparam int SCR_DEPTH = ROWS * COLS;
  localparam int HIS_DEPTH = HISTORY_LINES * COLS;

  localparam int CELL_W = 16;
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 48;

  localparam logic [7:0]        CH_NEWLINE = 8'h0a;
  localparam logic [7:0]        CH_RETURN  = 8'h0d;
  localparam logic [7:0]        CH_SPACE   = 8'h20;
  localparam logic [CELL_W-1:0] RESET_CELL = 16'h0720;
  localparam logic [7:0]        BLANK_ATTR_RESET = 8'h07;

  typedef enum logic [1:0] {
    CMD_WRITE       = 2'd0,
    CMD_CLEAR       = 2'd1,
    CMD_READ_SCREEN = 2'd2,
    CMD_READ_HIST   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    CELL_ZERO   = 2'd0,
    CELL_SCREEN = 2'd1,
    CELL_HIST   = 2'd2
  } cell_sel_e;

  // controller to datapath
  typedef struct packed {
    logic init_step;
    logic accept;
    logic clr_step;
    logic scroll_step;
    logic load_out;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_scroll;
    logic is_clear;
    logic sweep_last;
    logic scroll_last;
    logic out_free;
  } dp_sts_t;

  // logical screen row to physical row of the circular screen store
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] top,
                                                input logic [ROW_W-1:0] r);
    logic [ROWP_W-1:0] sum;
    sum = {1'b0, top} + {1'b0, r};
    if (sum >= ROWP_W'(ROWS)) begin
      sum = sum - ROWP_W'(ROWS);
    end
    return sum[ROW_W-1:0];
  endfunction

  function automatic logic [SCR_AW-1:0] scr_addr(input logic [ROW_W-1:0] r,
                                                 input logic [COL_W-1:0] c);
    return SCR_AW'(r) * SCR_AW'(COLS) + SCR_AW'(c);
  endfunction

  function automatic logic [HIS_AW-1:0] hist_addr(input logic [HIST_W-1:0] s,
                                                  input logic [COL_W-1:0] c);
    return HIS_AW'(s) * HIS_AW'(COLS) + HIS_AW'(c);
  endfunction

endpackage

// ----- design/text_console_writer.sv -----
// top level of the text console writer: stream ports, controller and datapath
//
// text-mode console engine (80 x 25 cells, 100-line scrollback). each request
// on the slave stream is one command: write a character, clear the screen, or
// read a screen or scrollback cell; each produces exactly one result carrying
// the cursor, the read cell and the scrollback position. one request is in
// work at a time. a write or read request goes from intake to the result state,
// which loads the result register once it is free; a write that leaves the last
// row scrolls, which copies the top row into scrollback and blanks it (one
// screen ram read per column plus pipeline fill). the screen is a circular row
// store, so a scroll moves no other rows. clear makes one screen ram write per
// cell. after reset a clearing pass fills the screen with the blank cell 0x0720
// while no request is taken; the configuration port is live throughout.
// scrollback slots never filled read as zero through the fill count, so the
// scrollback ram needs no clearing. a finished result waits in an output
// register, and the next request is taken while it does.
module text_console_writer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // blank attribute register
  input  logic                               cfg_we_i,
  input  logic [7:0]                         cfg_wdata_i,
  // request stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // char_code[7:0], attribute[15:8], read_row[22:16], read_col[29:23], zero[31:30]
  input  logic [tcw_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // command[1:0]
  input  logic [tcw_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // cursor_row[4:0], cursor_col[11:5], cell_word[27:12], history_next[34:28],
  // history_count[41:35], zero[47:42]
  output logic [tcw_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  tcw_pkg::ctrl_cmd_t cmd;
  tcw_pkg::dp_sts_t   sts;

  // controller: reset clearing pass, request intake, clear and scroll sweeps
  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath: cursor, rams and the result register; fields unpacked here
  tcw_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_cmd_i    (tcw_pkg::cmd_e'(s_axis_tuser)),
    .in_char_i   (s_axis_tdata[7:0]),
    .in_attr_i   (s_axis_tdata[15:8]),
    .in_row_i    (s_axis_tdata[22:16]),
    .in_col_i    (s_axis_tdata[29:23]),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ----- design/tcw_ram.sv -----
// generic simple dual-port ram with registered read
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/tcw_ctrl.sv -----
// sequencing state machine of the text console writer
module tcw_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tcw_pkg::dp_sts_t     sts_i,
  output tcw_pkg::ctrl_cmd_t   cmd_o
);

  typedef enum logic [4:0] {
    ST_INIT   = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_CLEAR  = 5'b00100,
    ST_SCROLL = 5'b01000,
    ST_DONE   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        cmd_o.init_step = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.need_scroll) begin
            state_d = ST_SCROLL;
          end else if (sts_i.is_clear) begin
            state_d = ST_CLEAR;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_DONE;
        end
      end
      ST_SCROLL: begin
        cmd_o.scroll_step = 1'b1;
        if (sts_i.scroll_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- design/tcw_dp.sv -----
// cursor, screen and scrollback stores, sweep counters and result register
module tcw_dp (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  tcw_pkg::ctrl_cmd_t               cmd_i,
  output tcw_pkg::dp_sts_t                 sts_o,
  input  logic                             cfg_we_i,
  input  logic [7:0]                       cfg_wdata_i,
  input  tcw_pkg::cmd_e                    in_cmd_i,
  input  logic [7:0]                       in_char_i,
  input  logic [7:0]                       in_attr_i,
  input  logic [6:0]                       in_row_i,
  input  logic [6:0]                       in_col_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic [tcw_pkg::OUT_TDATA_W-1:0]  out_data_o
);

  logic [tcw_pkg::ROW_W-1:0]  row_q, row_d, top_q, top_d;
  logic [tcw_pkg::COL_W-1:0]  col_q, col_d;
  logic [tcw_pkg::HIST_W-1:0] slot_q, slot_d;
  logic [tcw_pkg::FILL_W-1:0] filled_q, filled_d;
  logic [7:0]                 blank_attr_q, blank_attr_d;
  logic [tcw_pkg::SCR_AW-1:0] sweep_q, sweep_d;
  logic [tcw_pkg::CNT_W-1:0]  scr_cnt_q, scr_cnt_d;
  tcw_pkg::cell_sel_e         cell_sel_q, cell_sel_d;
  logic                       out_valid_q, out_valid_d;
  logic [tcw_pkg::OUT_TDATA_W-1:0] out_data_q, out_data_d;

  logic                        scr_we, scr_re, his_we, his_re;
  logic [tcw_pkg::SCR_AW-1:0]  scr_waddr, scr_raddr;
  logic [tcw_pkg::HIS_AW-1:0]  his_waddr, his_raddr;
  logic [tcw_pkg::CELL_W-1:0]  scr_wdata, his_wdata, scr_rdata, his_rdata;

  logic [tcw_pkg::ROW_W-1:0]  cur_phys, rd_phys;
  logic [tcw_pkg::COL_W-1:0]  scr_col_rd, scr_col_wr;
  logic [tcw_pkg::CELL_W-1:0] blank_cell, cell_word;
  logic is_write, is_nl, is_cr, at_last_col, at_last_row, line_end;
  logic scr_ok, hist_ok, sweep_last, scroll_last, put_char;

  always_comb begin
    blank_cell  = {blank_attr_q, tcw_pkg::CH_SPACE};
    cur_phys    = tcw_pkg::phys_row(top_q, row_q);
    rd_phys     = tcw_pkg::phys_row(top_q, tcw_pkg::ROW_W'(in_row_i));
    scr_col_rd  = tcw_pkg::COL_W'(scr_cnt_q);
    scr_col_wr  = tcw_pkg::COL_W'(scr_cnt_q - 1'b1);
    is_write    = (in_cmd_i == tcw_pkg::CMD_WRITE);
    is_nl       = (in_char_i == tcw_pkg::CH_NEWLINE);
    is_cr       = (in_char_i == tcw_pkg::CH_RETURN);
    at_last_col = (col_q == tcw_pkg::COL_W'(tcw_pkg::COLS - 1));
    at_last_row = (row_q == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1));
    line_end    = is_write && !is_cr && (is_nl || at_last_col);
    put_char    = is_write && !is_nl && !is_cr;
    scr_ok      = (in_row_i < 7'(tcw_pkg::ROWS)) && (in_col_i < 7'(tcw_pkg::COLS));
    // slots at or above the fill count were never written and read as zero
    hist_ok     = (in_row_i < filled_q) && (in_col_i < 7'(tcw_pkg::COLS));
    sweep_last  = (sweep_q == tcw_pkg::SCR_AW'(tcw_pkg::SCR_DEPTH - 1));
    scroll_last = (scr_cnt_q == tcw_pkg::CNT_W'(tcw_pkg::COLS));

    sts_o.need_scroll = line_end && at_last_row;
    sts_o.is_clear    = (in_cmd_i == tcw_pkg::CMD_CLEAR);
    sts_o.sweep_last  = sweep_last;
    sts_o.scroll_last = scroll_last;
    sts_o.out_free    = !out_valid_q || out_ready_i;
  end

  // ram port steering
  always_comb begin
    scr_we    = 1'b0;
    scr_waddr = sweep_q;
    scr_wdata = blank_cell;
    scr_re    = 1'b0;
    scr_raddr = tcw_pkg::scr_addr(rd_phys, tcw_pkg::COL_W'(in_col_i));
    his_we    = 1'b0;
    his_waddr = tcw_pkg::hist_addr(slot_q, scr_col_wr);
    his_wdata = scr_rdata;
    his_re    = 1'b0;
    his_raddr = tcw_pkg::hist_addr(tcw_pkg::HIST_W'(in_row_i), tcw_pkg::COL_W'(in_col_i));

    if (cmd_i.init_step) begin
      scr_we    = 1'b1;
      scr_wdata = tcw_pkg::RESET_CELL;
    end else if (cmd_i.clr_step) begin
      scr_we = 1'b1;
    end else if (cmd_i.scroll_step) begin
      // read top row one column ahead of the history copy and blanking
      if (!scroll_last) begin
        scr_re    = 1'b1;
        scr_raddr = tcw_pkg::scr_addr(top_q, scr_col_rd);
      end
      if (scr_cnt_q != '0) begin
        scr_we    = 1'b1;
        scr_waddr = tcw_pkg::scr_addr(top_q, scr_col_wr);
        his_we    = 1'b1;
      end
    end else if (cmd_i.accept) begin
      if (put_char) begin
        scr_we    = 1'b1;
        scr_waddr = tcw_pkg::scr_addr(cur_phys, col_q);
        scr_wdata = {in_attr_i, in_char_i};
      end
      scr_re = (in_cmd_i == tcw_pkg::CMD_READ_SCREEN) && scr_ok;
      his_re = (in_cmd_i == tcw_pkg::CMD_READ_HIST) && hist_ok;
    end
  end

  always_comb begin
    case (cell_sel_q)
      tcw_pkg::CELL_SCREEN: cell_word = scr_rdata;
      tcw_pkg::CELL_HIST:   cell_word = his_rdata;
      default:              cell_word = '0;
    endcase
  end

  always_comb begin
    row_d        = row_q;
    col_d        = col_q;
    top_d        = top_q;
    slot_d       = slot_q;
    filled_d     = filled_q;
    blank_attr_d = cfg_we_i ? cfg_wdata_i : blank_attr_q;
    sweep_d      = sweep_q;
    scr_cnt_d    = scr_cnt_q;
    cell_sel_d   = cell_sel_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;

    if (cmd_i.init_step || cmd_i.clr_step) begin
      sweep_d = sweep_last ? '0 : sweep_q + 1'b1;
    end
    if (cmd_i.clr_step && sweep_last) begin
      row_d = '0;
      col_d = '0;
      top_d = '0;
    end

    if (cmd_i.accept) begin
      if (line_end) begin
        // last row waits for the scroll to place the cursor
        if (!at_last_row) begin
          row_d = row_q + 1'b1;
          col_d = '0;
        end
      end else if (put_char) begin
        col_d = col_q + 1'b1;
      end
      if ((in_cmd_i == tcw_pkg::CMD_READ_SCREEN) && scr_ok) begin
        cell_sel_d = tcw_pkg::CELL_SCREEN;
      end else if ((in_cmd_i == tcw_pkg::CMD_READ_HIST) && hist_ok) begin
        cell_sel_d = tcw_pkg::CELL_HIST;
      end else begin
        cell_sel_d = tcw_pkg::CELL_ZERO;
      end
    end

    if (cmd_i.scroll_step) begin
      if (scroll_last) begin
        scr_cnt_d = '0;
        top_d     = (top_q == tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1)) ? '0 : top_q + 1'b1;
        slot_d    = (slot_q == tcw_pkg::HIST_W'(tcw_pkg::HISTORY_LINES - 1)) ?
                    '0 : slot_q + 1'b1;
        if (filled_q != tcw_pkg::FILL_W'(tcw_pkg::HISTORY_LINES)) begin
          filled_d = filled_q + 1'b1;
        end
        row_d = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
        col_d = '0;
      end else begin
        scr_cnt_d = scr_cnt_q + 1'b1;
      end
    end

    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
      out_data_d  = {6'd0, 7'(filled_q), 7'(slot_q), cell_word, 7'(col_q), 5'(row_q)};
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q        <= '0;
      col_q        <= '0;
      top_q        <= '0;
      slot_q       <= '0;
      filled_q     <= '0;
      blank_attr_q <= tcw_pkg::BLANK_ATTR_RESET;
      sweep_q      <= '0;
      scr_cnt_q    <= '0;
      cell_sel_q   <= tcw_pkg::CELL_ZERO;
      out_valid_q  <= 1'b0;
    end else begin
      row_q        <= row_d;
      col_q        <= col_d;
      top_q        <= top_d;
      slot_q       <= slot_d;
      filled_q     <= filled_d;
      blank_attr_q <= blank_attr_d;
      sweep_q      <= sweep_d;
      scr_cnt_q    <= scr_cnt_d;
      cell_sel_q   <= cell_sel_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (tcw_pkg::SCR_DEPTH)
  ) u_screen_ram (
    .clk_i   (clk_i),
    .we_i    (scr_we),
    .waddr_i (scr_waddr),
    .wdata_i (scr_wdata),
    .re_i    (scr_re),
    .raddr_i (scr_raddr),
    .rdata_o (scr_rdata)
  );

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (tcw_pkg::HIS_DEPTH)
  ) u_history_ram (
    .clk_i   (clk_i),
    .we_i    (his_we),
    .waddr_i (his_waddr),
    .wdata_i (his_wdata),
    .re_i    (his_re),
    .raddr_i (his_raddr),
    .rdata_o (his_rdata)
  );

endmodule

// ----- bench/text_console_writer_tb.sv -----
// self-checking stream testbench for the text console writer
module text_console_writer_tb;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 12;
  localparam int RAND_PER_PHASE = 400;
  localparam int HOLD_CYCLES    = 600;   // receiver hold-off in the pressure phase
  localparam int DRAIN_CYCLES   = 200;   // quiet time after the last result
  localparam int CYCLE_LIMIT    = 2000000;
  localparam int MAX_PRINTED    = 40;

  // one request as the console sees it
  typedef struct packed {
    tcw_pkg::cmd_e cmd;
    logic [7:0]    ch;
    logic [7:0]    attr;
    logic [6:0]    rrow;
    logic [6:0]    rcol;
  } console_req_t;

  // one result: cursor, read cell, scrollback position
  typedef struct packed {
    logic [4:0]  crow;
    logic [6:0]  ccol;
    logic [15:0] cword;
    logic [6:0]  hnext;
    logic [6:0]  hcount;
  } console_result_t;

  // a directed row; when typed is set the result is written out by hand
  typedef struct packed {
    console_req_t    req;
    logic            typed;
    console_result_t want;
  } directed_row_t;

  typedef struct packed {
    logic            typed;
    console_result_t want;
  } typed_slot_t;

  // how the two sides idle in each phase
  typedef enum logic [2:0] {
    PH_STEADY,
    PH_SEND_GAPS,
    PH_RECV_STALL,
    PH_BOTH,
    PH_HOLDOFF
  } phase_kind_e;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            cfg_we_i      = 1'b0;
  logic [7:0]                      cfg_wdata_i   = '0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [tcw_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [tcw_pkg::IN_TUSER_W-1:0]  s_axis_tuser  = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [tcw_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  phase_kind_e phase_kind = PH_STEADY;

  text_console_writer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // console predictor: its own copy of the screen, the scrollback and cursor
  // ---------------------------------------------------------------------------
  logic [15:0] screen_q [tcw_pkg::ROWS][tcw_pkg::COLS];
  logic [15:0] history_q [tcw_pkg::HISTORY_LINES][tcw_pkg::COLS];
  int          cur_row;
  int          cur_col;
  int          hist_slot;
  int          hist_fill;
  logic [7:0]  blank_attr;

  // coverage counters for the summary
  int n_requests, n_writes, n_clears, n_screen_reads, n_hist_reads;
  int n_scrolls, n_hist_hits, n_results, n_cfg_writes, mismatches;

  console_result_t pending_results [$];   // results still owed by the block
  typed_slot_t     typed_results [$];     // hand-written results, one per request

  function automatic void blank_screen_row(input int r);
    for (int c = 0; c < tcw_pkg::COLS; c++) begin
      screen_q[r][c] = {blank_attr, tcw_pkg::CH_SPACE};
    end
  endfunction

  // applies one request to the predicted console and returns its result
  function automatic console_result_t console_step(input console_req_t rq);
    console_result_t res;
    logic            advance;
    res     = '0;
    advance = 1'b0;
    case (rq.cmd)
      tcw_pkg::CMD_WRITE: begin
        n_writes++;
        // newline only moves the cursor, carriage return does nothing at all
        if (rq.ch == tcw_pkg::CH_NEWLINE) begin
          advance = 1'b1;
        end else if (rq.ch != tcw_pkg::CH_RETURN) begin
          screen_q[cur_row][cur_col] = {rq.attr, rq.ch};
          cur_col++;
          if (cur_col >= tcw_pkg::COLS) begin
            advance = 1'b1;
          end
        end
        if (advance) begin
          cur_col = 0;
          cur_row++;
          if (cur_row >= tcw_pkg::ROWS) begin
            // top row into the scrollback, shift up, blank the bottom row
            n_scrolls++;
            for (int c = 0; c < tcw_pkg::COLS; c++) begin
              history_q[hist_slot][c] = screen_q[0][c];
            end
            hist_slot = (hist_slot + 1) % tcw_pkg::HISTORY_LINES;
            if (hist_fill < tcw_pkg::HISTORY_LINES) begin
              hist_fill++;
            end
            for (int r = 0; r + 1 < tcw_pkg::ROWS; r++) begin
              for (int c = 0; c < tcw_pkg::COLS; c++) begin
                screen_q[r][c] = screen_q[r + 1][c];
              end
            end
            blank_screen_row(tcw_pkg::ROWS - 1);
            cur_row = tcw_pkg::ROWS - 1;
          end
        end
      end
      tcw_pkg::CMD_CLEAR: begin
        n_clears++;
        for (int r = 0; r < tcw_pkg::ROWS; r++) begin
          blank_screen_row(r);
        end
        cur_row = 0;
        cur_col = 0;
      end
      tcw_pkg::CMD_READ_SCREEN: begin
        n_screen_reads++;
        // out-of-range rows and columns read as zero
        if (rq.rrow < 7'(tcw_pkg::ROWS) && rq.rcol < 7'(tcw_pkg::COLS)) begin
          res.cword = screen_q[rq.rrow][rq.rcol];
        end
      end
      default: begin
        n_hist_reads++;
        // out-of-range slots read as zero, slots never filled hold zero
        if (rq.rrow < 7'(tcw_pkg::HISTORY_LINES) && rq.rcol < 7'(tcw_pkg::COLS)) begin
          res.cword = history_q[rq.rrow][rq.rcol];
          if (res.cword != '0) begin
            n_hist_hits++;
          end
        end
      end
    endcase
    res.crow   = 5'(cur_row);
    res.ccol   = 7'(cur_col);
    res.hnext  = 7'(hist_slot);
    res.hcount = 7'(hist_fill);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("mismatch at result %0d: %s got %0d expected %0d",
               n_results, what, got, want);
    end
  endtask

  // ---------------------------------------------------------------------------
  // scoreboard: predicts on every accepted request, checks every result
  // prediction runs first so a push and a pop at one edge cannot race
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    console_req_t    rq;
    console_result_t pred;
    console_result_t got;
    console_result_t want;
    typed_slot_t     ts;
    if (rst_ni) begin
      if (cfg_we_i) begin
        blank_attr = cfg_wdata_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        rq.cmd  = tcw_pkg::cmd_e'(s_axis_tuser);
        rq.ch   = s_axis_tdata[7:0];
        rq.attr = s_axis_tdata[15:8];
        rq.rrow = s_axis_tdata[22:16];
        rq.rcol = s_axis_tdata[29:23];
        n_requests++;
        pred = console_step(rq);
        ts   = (typed_results.size() != 0) ? typed_results.pop_front() : '0;
        pending_results.push_back(ts.typed ? ts.want : pred);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        got.crow   = m_axis_tdata[4:0];
        got.ccol   = m_axis_tdata[11:5];
        got.cword  = m_axis_tdata[27:12];
        got.hnext  = m_axis_tdata[34:28];
        got.hcount = m_axis_tdata[41:35];
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, cell", got.cword, 0);
        end else begin
          want = pending_results.pop_front();
          if (got.crow != want.crow)     report_mismatch("cursor_row", got.crow, want.crow);
          if (got.ccol != want.ccol)     report_mismatch("cursor_col", got.ccol, want.ccol);
          if (got.cword != want.cword)   report_mismatch("cell_word", got.cword, want.cword);
          if (got.hnext != want.hnext)   report_mismatch("history_next", got.hnext, want.hnext);
          if (got.hcount != want.hcount) report_mismatch("history_count", got.hcount, want.hcount);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls per phase, plus one long hold-off that lets the
  // block fill up and push back on the request side
  // ---------------------------------------------------------------------------
  int hold_cnt = 0;

  always @(posedge clk_i) begin
    int stall_pct;
    case (phase_kind)
      PH_RECV_STALL: stall_pct = 86;
      PH_BOTH:       stall_pct = 33;
      default:       stall_pct = 0;
    endcase
    if (phase_kind == PH_HOLDOFF && hold_cnt < HOLD_CYCLES) begin
      hold_cnt      <= hold_cnt + 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // run-away guard
  int cycle_cnt = 0;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed",
               cycle_cnt, pending_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sender
  // ---------------------------------------------------------------------------

  // offers one request and returns at the edge where it is taken; tvalid is
  // left high so back-to-back requests need only one assignment per edge
  task automatic send_request(input console_req_t rq, input logic typed,
                              input console_result_t want);
    int gap_pct;
    case (phase_kind)
      PH_SEND_GAPS: gap_pct = 86;
      PH_BOTH:      gap_pct = 33;
      default:      gap_pct = 0;
    endcase
    while ($urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    typed_results.push_back({typed, want});
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, rq.rcol, rq.rrow, rq.attr, rq.ch};
    s_axis_tuser  <= rq.cmd;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
  endtask

  // waits until every result is in; the first edge lets the last push land
  task automatic settle();
    @(posedge clk_i);
    while (pending_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_blank_attr(input logic [7:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    n_cfg_writes++;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // directed part, run with the reset blank attribute 0x07; rows with typed
  // set carry the result by hand, the others go through the predictor
  directed_row_t directed_tab [22] = '{
    // fresh screen holds the reset blank everywhere
    '{'{tcw_pkg::CMD_READ_SCREEN, 8'hff, 8'hff, 7'd0,   7'd0  },
      1'b1, '{5'd0, 7'd0, 16'h0720, 7'd0, 7'd0}},
    '{'{tcw_pkg::CMD_READ_SCREEN, 8'h00, 8'h00, 7'd24,  7'd79 },
      1'b1, '{5'd0, 7'd0, 16'h0720, 7'd0, 7'd0}},
    // reads past the last row or column
    '{'{tcw_pkg::CMD_READ_SCREEN, 8'h00, 8'h00, 7'd25,  7'd0  },
      1'b1, '{5'd0, 7'd0, 16'h0000, 7'd0, 7'd0}},
    '{'{tcw_pkg::CMD_READ_SCREEN, 8'h00, 8'h00, 7'd0,   7'd80 },
      1'b1, '{5'd0, 7'd0, 16'h0000, 7'd0, 7'd0}},
    '{'{tcw_pkg::CMD_READ_SCREEN, 8'hff, 8'hff, 7'd127, 7'd127},
      1'b1, '{5'd0, 7'd0, 16'h0000, 7'd0, 7'd0}},
    // scrollback never filled, then slots and columns out of range
    '{'{tcw_pkg::CMD_READ_HIST,   8'h00, 8'h00, 7'd0,   7'd0  },
      1'b1, '{5'd0, 7'd0, 16'h0000, 7'd0, 7'd0}},
    '{'{tcw_pkg::CMD_READ_HIST,   8'h00, 8'h00, 7'd99,  7'd79 },
      1'b1, '{5'd0, 7'd0, 16'h0000, 7'd0, 7'd0}},
    '{'{tcw_pkg::CMD_READ_HIST,   8'h00, 8'h00, 7'd100, 7'd0  },
      1'b1, '{5'd0, 7'd0, 16'h0000, 7'd0, 7'd0}},
    '{'{tcw_pkg::CMD_READ_HIST,   8'hff, 8'hff, 7'd127, 7'd127},
      1'b1, '{5'd0, 7'd0, 16'h0000, 7'd0, 7'd0}},
    // character and attribute extremes
    '{'{tcw_pkg::CMD_WRITE,       8'h41, 8'h1e, 7'd127, 7'd127},
      1'b1, '{5'd0, 7'd1, 16'h0000, 7'd0, 7'd0}},
    '{'{tcw_pkg::CMD_WRITE,       8'hff, 8'hff, 7'd0,   7'd0  },
      1'b1, '{5'd0, 7'd2, 16'h0000, 7'd0, 7'd0}},
    '{'{tcw_pkg::CMD_WRITE,       8'h00, 8'h00, 7'd0,   7'd0  },
      1'b1, '{5'd0, 7'd3, 16'h0000, 7'd0, 7'd0}},
    // carriage return leaves cursor and screen alone
    '{'{tcw_pkg::CMD_WRITE,       8'h0d, 8'h55, 7'd0,   7'd0  },
      1'b1, '{5'd0, 7'd3, 16'h0000, 7'd0, 7'd0}},
    '{'{tcw_pkg::CMD_READ_SCREEN, 8'h00, 8'h00, 7'd0,   7'd0  },
      1'b1, '{5'd0, 7'd3, 16'h1e41, 7'd0, 7'd0}},
    '{'{tcw_pkg::CMD_READ_SCREEN, 8'h00, 8'h00, 7'd0,   7'd1  },
      1'b1, '{5'd0, 7'd3, 16'hffff, 7'd0, 7'd0}},
    '{'{tcw_pkg::CMD_READ_SCREEN, 8'h00, 8'h00, 7'd0,   7'd2  },
      1'b1, '{5'd0, 7'd3, 16'h0000, 7'd0, 7'd0}},
    '{'{tcw_pkg::CMD_READ_SCREEN, 8'h00, 8'h00, 7'd0,   7'd3  },
      1'b1, '{5'd0, 7'd3, 16'h0720, 7'd0, 7'd0}},
    // newline, one more character, then clear
    '{'{tcw_pkg::CMD_WRITE,       8'h0a, 8'haa, 7'd0,   7'd0  },
      1'b1, '{5'd1, 7'd0, 16'h0000, 7'd0, 7'd0}},
    '{'{tcw_pkg::CMD_WRITE,       8'h42, 8'h70, 7'd0,   7'd0  },
      1'b1, '{5'd1, 7'd1, 16'h0000, 7'd0, 7'd0}},
    '{'{tcw_pkg::CMD_CLEAR,       8'h42, 8'h70, 7'd5,   7'd5  },
      1'b1, '{5'd0, 7'd0, 16'h0000, 7'd0, 7'd0}},
    '{'{tcw_pkg::CMD_READ_SCREEN, 8'h00, 8'h00, 7'd1,   7'd0  },
      1'b1, '{5'd0, 7'd0, 16'h0720, 7'd0, 7'd0}},
    '{'{tcw_pkg::CMD_READ_SCREEN, 8'h00, 8'h00, 7'd24,  7'd79 },
      1'b0, '0}
  };

  // random phases: idling style and blank attribute for each
  phase_kind_e phase_plan [5] = '{PH_STEADY, PH_SEND_GAPS, PH_RECV_STALL, PH_BOTH, PH_HOLDOFF};

  initial begin
    console_req_t rq;
    logic [7:0]   attr_v;
    int           pick;

    // predictor reset state
    foreach (screen_q[r, c]) screen_q[r][c] = tcw_pkg::RESET_CELL;
    foreach (history_q[s, c]) history_q[s][c] = '0;
    cur_row    = 0;
    cur_col    = 0;
    hist_slot  = 0;
    hist_fill  = 0;
    blank_attr = tcw_pkg::BLANK_ATTR_RESET;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // the first request waits out the clearing pass through tready
    foreach (directed_tab[i]) begin
      send_request(directed_tab[i].req, directed_tab[i].typed, directed_tab[i].want);
    end
    s_axis_tvalid <= 1'b0;

    for (int p = 0; p < 5; p++) begin
      settle();
      // extremes first, then random attributes
      case (p)
        0:       attr_v = 8'h00;
        1:       attr_v = 8'hff;
        default: attr_v = 8'($urandom);
      endcase
      write_blank_attr(attr_v);
      phase_kind <= phase_plan[p];
      @(posedge clk_i);

      repeat (RAND_PER_PHASE) begin
        // every field random over its full width, then shaped per command
        rq.ch   = 8'($urandom);
        rq.attr = 8'($urandom);
        rq.rrow = 7'($urandom);
        rq.rcol = 7'($urandom);
        pick    = $urandom_range(0, 999);
        if (pick < 600) begin
          // mostly text with plenty of newlines so the screen keeps scrolling
          // and the scrollback wraps well past its capacity
          rq.cmd = tcw_pkg::CMD_WRITE;
          case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: rq.ch = tcw_pkg::CH_NEWLINE;
            5:             rq.ch = tcw_pkg::CH_RETURN;
            default:       ;
          endcase
        end else if (pick < 790) begin
          rq.cmd = tcw_pkg::CMD_READ_SCREEN;
          if ($urandom_range(0, 99) < 85) begin
            rq.rrow = 7'($urandom_range(0, tcw_pkg::ROWS - 1));
            rq.rcol = 7'($urandom_range(0, tcw_pkg::COLS - 1));
          end
        end else if (pick < 998) begin
          rq.cmd = tcw_pkg::CMD_READ_HIST;
          if ($urandom_range(0, 99) < 85) begin
            rq.rrow = 7'($urandom_range(0, tcw_pkg::HISTORY_LINES - 1));
            rq.rcol = 7'($urandom_range(0, tcw_pkg::COLS - 1));
          end
        end else begin
          // clears are rare: each one costs a full screen sweep
          rq.cmd = tcw_pkg::CMD_CLEAR;
        end
        send_request(rq, 1'b0, '0);
      end
      s_axis_tvalid <= 1'b0;
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    while (pending_results.size() != 0) begin
      report_mismatch("result never came, cell", 0, pending_results.pop_front().cword);
    end

    $display("requests %0d: writes %0d, clears %0d, screen reads %0d",
             n_requests, n_writes, n_clears, n_screen_reads);
    $display("scrollback reads %0d, scrolls %0d, scrollback full %0d, non-blank history %0d",
             n_hist_reads, n_scrolls, hist_fill == tcw_pkg::HISTORY_LINES, n_hist_hits);
    $display("blank settings %0d, mismatches %0d", n_cfg_writes, mismatches);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
